/* rtl/fbape_pkg.sv */
// ----------------------------------------------------------------------------
// fbape_pkg
// Types, constants and the channel blend function of the pixel engine.
// ----------------------------------------------------------------------------
package fbape_pkg;

  // Coordinates that pass clipping fit in the screen dimension width.
  localparam int unsigned COORD_W = 13;
  localparam int unsigned BPP_W   = 3;
  localparam int unsigned PITCH_W = 15;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned PX_W    = COORD_W + BPP_W;
  localparam int unsigned PY_W    = COORD_W + PITCH_W;
  // Room for the sum of both offsets plus the byte index of red.
  localparam int unsigned ADDR_W  = PY_W + 2;
  localparam int unsigned APB_AW  = 4;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

  localparam logic [1:0] REG_BPP    = 2'd0;
  localparam logic [1:0] REG_PITCH  = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  localparam logic [BPP_W-1:0]   BPP_RST    = 3'd4;
  localparam logic [PITCH_W-1:0] PITCH_RST  = 15'd2560;
  localparam logic [DIM_W-1:0]   WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0]   HEIGHT_RST = 13'd480;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

  localparam logic [1:0] BYTE_BLUE  = 2'd0;
  localparam logic [1:0] BYTE_GREEN = 2'd1;
  localparam logic [1:0] BYTE_RED   = 2'd2;

  typedef enum logic [1:0] {
    OP_READ,
    OP_READ_ZERO,
    OP_STORE,
    OP_BLEND
  } op_e;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_RD,
    B_CAP,
    B_WR,
    B_DONE
  } back_state_e;

  typedef struct packed {
    op_e             op;
    logic [PX_W-1:0] px;
    logic [PY_W-1:0] py;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic [7:0]      alpha;
  } entry_t;

  typedef struct packed {
    logic [BPP_W-1:0]   bpp;
    logic [PITCH_W-1:0] pitch;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
  } cfg_t;

  function automatic logic [7:0] mix8(input logic [7:0] a, input logic [7:0] fg,
                                      input logic [7:0] bg);
    logic [8:0]  wa;
    logic [8:0]  wb;
    logic [16:0] s;
    wa = {1'b0, a} + 9'd1;
    wb = 9'd256 - {1'b0, a};
    s  = 17'(wa) * 17'(fg) + 17'(wb) * 17'(bg);
    return s[15:8];
  endfunction

endpackage

/* rtl/fbape_if.sv */
// ----------------------------------------------------------------------------
// fbape_if
// Valid/ready channels of the pixel engine: requests in, read colors out.
// ----------------------------------------------------------------------------
interface fbape_req_if;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic signed [15:0] x_pos;
  logic signed [15:0] y_pos;
  logic [7:0]        red;
  logic [7:0]        green;
  logic [7:0]        blue;
  logic [7:0]        alpha;

  modport source (output valid, req_type, x_pos, y_pos, red, green, blue, alpha,
                  input ready);
  modport sink (input valid, req_type, x_pos, y_pos, red, green, blue, alpha,
                output ready);
endinterface

interface fbape_pix_if;
  logic        valid;
  logic        ready;
  logic [23:0] pixel_color;

  modport source (output valid, pixel_color, input ready);
  modport sink (input valid, pixel_color, output ready);
endinterface

/* rtl/framebuffer_alpha_pixel_engine.sv */
// ----------------------------------------------------------------------------
// framebuffer_alpha_pixel_engine
// Pixel read and alpha-blended pixel write port onto a byte-wide back buffer.
// ----------------------------------------------------------------------------
// After reset the engine zeroes the pixel store one byte per cycle, over all
// STORE_BYTES bytes (262144 at the default size); req.ready stays low during
// that pass while APB writes are still taken. The front end clips and
// classifies one request per cycle, while the queue has room, into a two-entry
// queue, and dropped writes (clipped or alpha zero) are never queued. The store
// sequencer passes a clipped read straight to the output; every other request
// touches three bytes through the single byte-wide port of the store: a read
// fetches each, an opaque write stores each, and a blend reads, mixes and
// writes each of them in turn. Read colors wait in an output register, so the
// engine keeps working while a result is not yet taken.
module framebuffer_alpha_pixel_engine import fbape_pkg::*; #(
  parameter int unsigned STORE_BYTES = 262144
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  fbape_req_if.sink         req,
  fbape_pix_if.source       rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t       cfg_q;
  cfg_t       cfg_d;
  logic [1:0] reg_idx;
  logic       cfg_wr;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  logic       clr_busy;
  entry_t     push_entry;
  entry_t     head_entry;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_BPP:    cfg_d.bpp    = pwdata[BPP_W-1:0];
        REG_PITCH:  cfg_d.pitch  = pwdata[PITCH_W-1:0];
        REG_WIDTH:  cfg_d.width  = pwdata[DIM_W-1:0];
        default:    cfg_d.height = pwdata[DIM_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BPP:    prdata = APB_DW'(cfg_q.bpp);
      REG_PITCH:  prdata = APB_DW'(cfg_q.pitch);
      REG_WIDTH:  prdata = APB_DW'(cfg_q.width);
      default:    prdata = APB_DW'(cfg_q.height);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bpp    <= BPP_RST;
      cfg_q.pitch  <= PITCH_RST;
      cfg_q.width  <= WIDTH_RST;
      cfg_q.height <= HEIGHT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  fbape_front u_front (
    .req        (req),
    .cfg_i      (cfg_q),
    .q_full_i   (q_full),
    .clr_busy_i (clr_busy),
    .push_o     (q_push),
    .entry_o    (push_entry)
  );

  fbape_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .pop_i   (q_pop),
    .entry_o (head_entry),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  fbape_back #(
    .STORE_BYTES (STORE_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .entry_i    (head_entry),
    .empty_i    (q_empty),
    .pop_o      (q_pop),
    .clr_busy_o (clr_busy),
    .rsp        (rsp)
  );

  // A request must never be pushed into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("request pushed into full queue");

  // No read color can appear while the store is still being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni) clr_busy |-> !rsp.valid)
    else $error("result presented during clearing pass");

  // Nothing may have entered the queue while the clearing pass ran.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $fell(clr_busy) |-> q_empty)
    else $error("request queued during clearing pass");

endmodule

/* rtl/fbape_ram.sv */
// ----------------------------------------------------------------------------
// fbape_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module fbape_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem[addr_i];
      end
    end
  end

endmodule

/* rtl/fbape_front.sv */
// ----------------------------------------------------------------------------
// fbape_front
// Request front end: clips, classifies and forms the address offsets.
// ----------------------------------------------------------------------------
module fbape_front import fbape_pkg::*; (
  fbape_req_if.sink req,
  input  cfg_t      cfg_i,
  input  logic      q_full_i,
  input  logic      clr_busy_i,
  output logic      push_o,
  output entry_t    entry_o
);

  logic               x_ok;
  logic               y_ok;
  logic               on_screen;
  logic               keep;
  logic [COORD_W-1:0] xs;
  logic [COORD_W-1:0] ys;

  assign x_ok      = !req.x_pos[15] && (req.x_pos[14:0] < 15'(cfg_i.width));
  assign y_ok      = !req.y_pos[15] && (req.y_pos[14:0] < 15'(cfg_i.height));
  assign on_screen = x_ok && y_ok;
  assign xs        = req.x_pos[COORD_W-1:0];
  assign ys        = req.y_pos[COORD_W-1:0];

  always_comb begin
    entry_o.px    = PX_W'(xs) * PX_W'(cfg_i.bpp);
    entry_o.py    = PY_W'(ys) * PY_W'(cfg_i.pitch);
    entry_o.red   = req.red;
    entry_o.green = req.green;
    entry_o.blue  = req.blue;
    entry_o.alpha = req.alpha;
    if (!req.req_type) begin
      entry_o.op = on_screen ? OP_READ : OP_READ_ZERO;
      keep       = 1'b1;
    end else begin
      entry_o.op = (req.alpha == ALPHA_OPAQUE) ? OP_STORE : OP_BLEND;
      // Clipped or fully transparent writes leave the store alone.
      keep       = on_screen && (req.alpha != ALPHA_CLEAR);
    end
  end

  assign req.ready = !q_full_i && !clr_busy_i;
  assign push_o    = req.valid && req.ready && keep;

endmodule

/* rtl/fbape_queue.sv */
// ----------------------------------------------------------------------------
// fbape_queue
// Short FIFO of classified requests between front end and store sequencer.
// ----------------------------------------------------------------------------
module fbape_queue import fbape_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  input  logic   pop_i,
  output entry_t entry_o,
  output logic   empty_o,
  output logic   full_o
);

  entry_t               slot_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wptr_q, wptr_d;
  logic [Q_PTR_W-1:0]   rptr_q, rptr_d;
  logic [Q_PTR_W:0]     cnt_q, cnt_d;
  logic                 do_push;
  logic                 do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (Q_PTR_W+1)'(Q_DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = slot_q[rptr_q];

  always_comb begin
    wptr_d = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q + (Q_PTR_W+1)'(do_push) - (Q_PTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= entry_i;
    end
  end

endmodule

/* rtl/fbape_back.sv */
// ----------------------------------------------------------------------------
// fbape_back
// Store sequencer: clears the pixel store, then runs reads, stores and blends
// one byte per step through the single RAM port.
// ----------------------------------------------------------------------------
module fbape_back import fbape_pkg::*; #(
  parameter int unsigned STORE_BYTES = 262144
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  entry_t    entry_i,
  input  logic      empty_i,
  output logic      pop_o,
  output logic      clr_busy_o,
  fbape_pix_if.source rsp
);

  localparam int unsigned RAM_AW = $clog2(STORE_BYTES);
  localparam logic [RAM_AW-1:0] CLR_LAST = RAM_AW'(STORE_BYTES - 1);

  back_state_e        state_q, state_d;
  op_e                op_q, op_d;
  logic [ADDR_W-1:0]  base_q, base_d;
  logic [7:0]         red_q, red_d;
  logic [7:0]         green_q, green_d;
  logic [7:0]         blue_q, blue_d;
  logic [7:0]         alpha_q, alpha_d;
  logic [1:0]         k_q, k_d;
  logic               inr_q, inr_d;
  logic [7:0]         wdat_q, wdat_d;
  logic [23:0]        acc_q, acc_d;
  logic [RAM_AW-1:0]  clr_q, clr_d;
  logic               out_valid_q, out_valid_d;
  logic [23:0]        pix_q, pix_d;

  logic [ADDR_W-1:0]  byte_addr;
  logic               in_rng;
  logic [7:0]         fg;
  logic [7:0]         old;
  logic               ram_en;
  logic               ram_we;
  logic [RAM_AW-1:0]  ram_addr;
  logic [7:0]         ram_wdata;
  logic [7:0]         ram_rdata;

  fbape_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign byte_addr = base_q + ADDR_W'(k_q);
  assign in_rng    = byte_addr < ADDR_W'(STORE_BYTES);
  // Bytes past the end of the store read as zero.
  assign old       = inr_q ? ram_rdata : 8'h00;

  always_comb begin
    unique case (k_q)
      BYTE_BLUE:  fg = blue_q;
      BYTE_GREEN: fg = green_q;
      default:    fg = red_q;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    base_d      = base_q;
    red_d       = red_q;
    green_d     = green_q;
    blue_d      = blue_q;
    alpha_d     = alpha_q;
    k_d         = k_q;
    inr_d       = inr_q;
    wdat_d      = wdat_q;
    acc_d       = acc_q;
    clr_d       = clr_q;
    pix_d       = pix_q;
    out_valid_d = out_valid_q && !rsp.ready;
    pop_o       = 1'b0;
    ram_en      = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = byte_addr[RAM_AW-1:0];
    ram_wdata   = wdat_q;

    unique case (state_q)
      B_CLEAR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = 8'h00;
        clr_d     = clr_q + 1'b1;
        if (clr_q == CLR_LAST) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          op_d    = entry_i.op;
          base_d  = ADDR_W'(entry_i.px) + ADDR_W'(entry_i.py);
          red_d   = entry_i.red;
          green_d = entry_i.green;
          blue_d  = entry_i.blue;
          alpha_d = entry_i.alpha;
          k_d     = BYTE_BLUE;
          acc_d   = '0;
          unique case (entry_i.op)
            OP_READ_ZERO: state_d = B_DONE;
            OP_STORE:     state_d = B_WR;
            default:      state_d = B_RD;
          endcase
        end
      end
      B_RD: begin
        ram_en  = in_rng;
        inr_d   = in_rng;
        state_d = B_CAP;
      end
      B_CAP: begin
        if (op_q == OP_READ) begin
          unique case (k_q)
            BYTE_BLUE:  acc_d[7:0]   = old;
            BYTE_GREEN: acc_d[15:8]  = old;
            default:    acc_d[23:16] = old;
          endcase
          if (k_q == BYTE_RED) begin
            state_d = B_DONE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = B_RD;
          end
        end else begin
          wdat_d  = mix8(alpha_q, fg, old);
          state_d = B_WR;
        end
      end
      B_WR: begin
        ram_en    = in_rng;
        ram_we    = in_rng;
        ram_wdata = (op_q == OP_STORE) ? fg : wdat_q;
        if (k_q == BYTE_RED) begin
          state_d = B_IDLE;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = (op_q == OP_STORE) ? B_WR : B_RD;
        end
      end
      B_DONE: begin
        // Hand the color over once the output register is free or draining.
        if (!out_valid_q || rsp.ready) begin
          out_valid_d = 1'b1;
          pix_d       = acc_q;
          state_d     = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      op_q        <= OP_READ;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      k_q         <= k_d;
      op_q        <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q      <= base_d;
    red_q       <= red_d;
    green_q     <= green_d;
    blue_q      <= blue_d;
    alpha_q     <= alpha_d;
    inr_q       <= inr_d;
    wdat_q      <= wdat_d;
    acc_q       <= acc_d;
    pix_q       <= pix_d;
  end

  assign clr_busy_o      = (state_q == B_CLEAR);
  assign rsp.valid       = out_valid_q;
  assign rsp.pixel_color = pix_q;

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the alpha-blending pixel engine. A scoreboard keeps
// its own copy of the byte store and of the screen geometry, predicts each
// read color at request transfer time and compares it with the colors that
// come out. Geometry is reprogrammed over APB between phases of random
// traffic, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb import fbape_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STORE_BYTES  = 262144;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT  = 2000000;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
  } pix_req_t;

  logic clk_i;
  logic rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  fbape_req_if req_if();
  fbape_pix_if pix_if();

  framebuffer_alpha_pixel_engine #(
    .STORE_BYTES(STORE_BYTES)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_if),
    .rsp    (pix_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Scoreboard copy of the frame buffer and geometry.
  bit [7:0]           fb_bytes [STORE_BYTES];
  logic [BPP_W-1:0]   cfg_bpp    = BPP_RST;
  logic [PITCH_W-1:0] cfg_pitch  = PITCH_RST;
  logic [DIM_W-1:0]   cfg_width  = WIDTH_RST;
  logic [DIM_W-1:0]   cfg_height = HEIGHT_RST;

  pix_req_t    pend_reqs[$];
  logic [23:0] expected_colors[$];
  pix_req_t    cur_req;
  int unsigned send_gap;
  int unsigned take_stall;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] peek_byte(logic [63:0] addr);
    return (addr < STORE_BYTES) ? fb_bytes[addr] : 8'h00;
  endfunction

  function automatic void poke_byte(logic [63:0] addr, logic [7:0] val);
    if (addr < STORE_BYTES) fb_bytes[addr] = val;
  endfunction

  function automatic logic [7:0] blend_channel(logic [7:0] a, logic [7:0] fg, logic [7:0] bg);
    logic [31:0] acc;
    acc = (32'(a) + 32'd1) * 32'(fg) + (32'd256 - 32'(a)) * 32'(bg);
    return acc[15:8];
  endfunction

  // Applies one transferred request to the scoreboard store; reads queue a color.
  function automatic void predict_request(pix_req_t rq);
    int          xi;
    int          yi;
    bit          visible;
    logic [63:0] where;
    logic [7:0]  old_b;
    logic [7:0]  old_g;
    logic [7:0]  old_r;
    xi = rq.x_pos;
    yi = rq.y_pos;
    visible = (xi >= 0) && (yi >= 0) && (xi < int'(cfg_width)) && (yi < int'(cfg_height));
    where = 64'd0;
    if (visible) where = 64'(xi) * 64'(cfg_bpp) + 64'(yi) * 64'(cfg_pitch);
    if (rq.req_type == REQ_READ) begin
      if (visible) expected_colors.push_back({peek_byte(where + 2), peek_byte(where + 1),
                                              peek_byte(where)});
      else expected_colors.push_back(24'h000000);
      return;
    end
    if (!visible || rq.alpha == ALPHA_CLEAR) return;
    if (rq.alpha == ALPHA_OPAQUE) begin
      poke_byte(where, rq.blue);
      poke_byte(where + 1, rq.green);
      poke_byte(where + 2, rq.red);
    end else begin
      old_b = peek_byte(where);
      old_g = peek_byte(where + 1);
      old_r = peek_byte(where + 2);
      poke_byte(where, blend_channel(rq.alpha, rq.blue, old_b));
      poke_byte(where + 1, blend_channel(rq.alpha, rq.green, old_g));
      poke_byte(where + 2, blend_channel(rq.alpha, rq.red, old_r));
    end
  endfunction

  function automatic pix_req_t mk_req(logic kind, int x, int y, logic [7:0] r, logic [7:0] g,
                                      logic [7:0] b, logic [7:0] a);
    pix_req_t rq;
    rq.req_type = kind;
    rq.x_pos    = 16'(x);
    rq.y_pos    = 16'(y);
    rq.red      = r;
    rq.green    = g;
    rq.blue     = b;
    rq.alpha    = a;
    return rq;
  endfunction

  // Half the time a small window near the origin so that reads hit written pixels.
  function automatic logic signed [15:0] pick_coord(int unsigned dim);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      if (dim == 0) return 16'sd0;
      return 16'($urandom_range(0, ((dim > 12) ? 12 : dim) - 1));
    end else if (sel < 60) begin
      if (dim == 0) return 16'sd0;
      return 16'($urandom_range(0, dim - 1));
    end else if (sel < 75) begin
      return 16'(int'(dim) + int'($urandom_range(0, 3)) - 2);
    end else if (sel < 85) begin
      return 16'(-int'($urandom_range(0, 3)));
    end
    return 16'($urandom());
  endfunction

  function automatic pix_req_t random_request();
    pix_req_t    rq;
    int unsigned sel;
    logic [31:0] y0;
    logic [31:0] x0;
    rq.req_type = ($urandom_range(0, 99) < 55) ? REQ_READ : REQ_WRITE;
    if ($urandom_range(0, 99) < 10 && cfg_bpp != 0 && cfg_pitch != 0 && cfg_height != 0) begin
      // Aim at the pixels whose bytes straddle the end of the store.
      y0 = STORE_BYTES / cfg_pitch;
      if (y0 >= cfg_height) y0 = cfg_height - 1;
      x0 = (STORE_BYTES - y0 * cfg_pitch) / cfg_bpp + $urandom_range(0, 2) - 1;
      rq.x_pos = 16'(x0);
      rq.y_pos = 16'(y0);
    end else begin
      rq.x_pos = pick_coord(cfg_width);
      rq.y_pos = pick_coord(cfg_height);
    end
    rq.red   = 8'($urandom());
    rq.green = 8'($urandom());
    rq.blue  = 8'($urandom());
    sel = $urandom_range(0, 99);
    if (sel < 20) rq.alpha = ALPHA_OPAQUE;
    else if (sel < 30) rq.alpha = ALPHA_CLEAR;
    else if (sel < 35) rq.alpha = 8'd1;
    else if (sel < 40) rq.alpha = 8'd254;
    else rq.alpha = 8'($urandom());
    return rq;
  endfunction

  // APB write; bits above the register width carry random junk.
  task automatic write_reg(logic [1:0] idx, int unsigned value);
    int unsigned w;
    logic [31:0] data;
    case (idx)
      REG_BPP: begin
        w = BPP_W;
        cfg_bpp = value[BPP_W-1:0];
      end
      REG_PITCH: begin
        w = PITCH_W;
        cfg_pitch = value[PITCH_W-1:0];
      end
      REG_WIDTH: begin
        w = DIM_W;
        cfg_width = value[DIM_W-1:0];
      end
      default: begin
        w = DIM_W;
        cfg_height = value[DIM_W-1:0];
      end
    endcase
    data = (32'(value) & ((32'd1 << w) - 1)) | ($urandom() << w);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Sampled at the falling edge so that both always blocks have settled.
  task automatic wait_results();
    do @(negedge clk_i);
    while (pend_reqs.size() != 0 || req_if.valid || expected_colors.size() != 0);
  endtask

  task automatic run_phase(int unsigned bpp, int unsigned pitch, int unsigned w, int unsigned h,
                           int unsigned n_items, int unsigned idle);
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    write_reg(REG_BPP, bpp);
    write_reg(REG_PITCH, pitch);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    idle_pct  = idle;
    stall_pct = idle;
    repeat (n_items) pend_reqs.push_back(random_request());
  endtask

  // Request driver.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) predict_request(cur_req);
      if (!req_if.valid || req_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_if.valid <= 1'b0;
        end else if (pend_reqs.size() == 0) begin
          req_if.valid <= 1'b0;
        end else if ($urandom_range(0, 99) < idle_pct) begin
          send_gap = $urandom_range(1, 11) - 1;
          req_if.valid <= 1'b0;
        end else begin
          cur_req = pend_reqs.pop_front();
          req_if.valid    <= 1'b1;
          req_if.req_type <= cur_req.req_type;
          req_if.x_pos    <= cur_req.x_pos;
          req_if.y_pos    <= cur_req.y_pos;
          req_if.red      <= cur_req.red;
          req_if.green    <= cur_req.green;
          req_if.blue     <= cur_req.blue;
          req_if.alpha    <= cur_req.alpha;
        end
      end
    end
  end

  // Color monitor with random back-pressure.
  always @(posedge clk_i) begin
    logic [23:0] want;
    if (!rst_ni) begin
      pix_if.ready <= 1'b0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        if (expected_colors.size() == 0) begin
          $error("pixel_color %06h transferred with no read outstanding", pix_if.pixel_color);
          mismatch_cnt++;
        end else begin
          want = expected_colors.pop_front();
          if (pix_if.pixel_color !== want) begin
            $error("pixel_color mismatch: expected %06h, actual %06h", want, pix_if.pixel_color);
            mismatch_cnt++;
          end
        end
      end
      if (take_stall > 0) begin
        take_stall--;
        pix_if.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        take_stall = $urandom_range(1, 11) - 1;
        pix_if.ready <= 1'b0;
      end else begin
        pix_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_READ;
    req_if.x_pos    = '0;
    req_if.y_pos    = '0;
    req_if.red      = '0;
    req_if.green    = '0;
    req_if.blue     = '0;
    req_if.alpha    = '0;
    pix_if.ready    = 1'b0;
    send_gap        = 0;
    take_stall      = 0;
    idle_pct        = 20;
    stall_pct       = 20;
    mismatch_cnt    = 0;
    cycle_cnt       = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset geometry; the store starts out cleared.
    pend_reqs.push_back(mk_req(REQ_READ, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00));
    pend_reqs.push_back(mk_req(REQ_WRITE, 0, 0, 8'hff, 8'hff, 8'hff, ALPHA_OPAQUE));
    pend_reqs.push_back(mk_req(REQ_READ, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00));
    pend_reqs.push_back(mk_req(REQ_WRITE, 0, 0, 8'h00, 8'h00, 8'h00, 8'd1));
    pend_reqs.push_back(mk_req(REQ_READ, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00));
    pend_reqs.push_back(mk_req(REQ_WRITE, 1, 0, 8'hff, 8'h80, 8'h01, 8'd254));
    pend_reqs.push_back(mk_req(REQ_READ, 1, 0, 8'h00, 8'h00, 8'h00, 8'h00));
    pend_reqs.push_back(mk_req(REQ_WRITE, 2, 0, 8'hff, 8'hff, 8'hff, ALPHA_CLEAR));
    pend_reqs.push_back(mk_req(REQ_READ, 2, 0, 8'h00, 8'h00, 8'h00, 8'h00));
    pend_reqs.push_back(mk_req(REQ_WRITE, -1, 0, 8'hff, 8'hff, 8'hff, ALPHA_OPAQUE));
    pend_reqs.push_back(mk_req(REQ_READ, -1, 0, 8'h00, 8'h00, 8'h00, 8'h00));
    pend_reqs.push_back(mk_req(REQ_WRITE, 640, 3, 8'h12, 8'h34, 8'h56, ALPHA_OPAQUE));
    pend_reqs.push_back(mk_req(REQ_READ, 640, 3, 8'h00, 8'h00, 8'h00, 8'h00));
    pend_reqs.push_back(mk_req(REQ_READ, 3, 480, 8'h00, 8'h00, 8'h00, 8'h00));
    pend_reqs.push_back(mk_req(REQ_READ, -32768, -32768, 8'hff, 8'hff, 8'hff, 8'hff));
    pend_reqs.push_back(mk_req(REQ_WRITE, 32767, 32767, 8'hff, 8'hff, 8'hff, ALPHA_OPAQUE));
    pend_reqs.push_back(mk_req(REQ_READ, 32767, 32767, 8'h00, 8'h00, 8'h00, 8'h00));
    // Visible but far past the end of the store.
    pend_reqs.push_back(mk_req(REQ_WRITE, 639, 479, 8'haa, 8'h55, 8'hcc, ALPHA_OPAQUE));
    pend_reqs.push_back(mk_req(REQ_READ, 639, 479, 8'h00, 8'h00, 8'h00, 8'h00));
    // Last pixel that still fits the store entirely.
    pend_reqs.push_back(mk_req(REQ_WRITE, 255, 102, 8'h01, 8'h02, 8'h03, ALPHA_OPAQUE));
    pend_reqs.push_back(mk_req(REQ_WRITE, 255, 102, 8'hfe, 8'hfd, 8'hfc, 8'd128));
    pend_reqs.push_back(mk_req(REQ_READ, 255, 102, 8'h00, 8'h00, 8'h00, 8'h00));
    repeat (200) pend_reqs.push_back(random_request());

    run_phase(3, 1, 4096, 4096, 250, 25);
    run_phase(4, 16384, 1, 4096, 150, 0);
    run_phase(7, 16383, 4096, 64, 200, 30);
    run_phase(0, 32767, 8191, 1, 100, 15);
    run_phase(5, 40, 0, 16, 60, 20);
    run_phase(1, 3, 8, 0, 40, 20);
    run_phase(6, 100, 16, 16, 200, 25);
    run_phase(3, 24, 8, 8, 150, 30);
    // Let the engine run dry before the rest of this geometry.
    wait_results();
    repeat (150) pend_reqs.push_back(random_request());
    run_phase(2, 64, 16, 16, 300, 0);

    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_colors.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
